// ===== src/text_line_folder_macros.svh =====
// Assertion macros shared by the text line folder modules.
`ifndef TEXT_LINE_FOLDER_MACROS_SVH
`define TEXT_LINE_FOLDER_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define TLF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define TLF_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/tlf_pkg.sv =====
// Types, constants and helper functions of the text line folder.
package tlf_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LEN_W     = $clog2(MAX_WIDTH + 1);

    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int LW_W       = 6;
    localparam int TW_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [COL_W-1:0]  COL_SAT  = {COL_W{1'b1}};
    localparam logic [LW_W-1:0]   LW_RESET = LW_W'(10);
    localparam logic [TW_W-1:0]   TW_RESET = TW_W'(4);

    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_RD,
        EMIT_CHAR,
        EMIT_NL
    } emit_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LEN_M1
    } idx_op_t;

    typedef enum logic [1:0] {
        SEG_NONE,
        SEG_CLEAR,
        SEG_ADVANCE,
        SEG_STORE
    } seg_op_t;

    // Control word driven by the sequencer into the datapath.
    typedef struct packed {
        logic    idle;
        emit_t   emit;
        logic    last;
        idx_op_t idx_op;
        seg_op_t seg_op;
        logic    col_acc;
        logic    p_load;
    } ctl_t;

    // Status returned by the datapath for jumps and dispatch.
    typedef struct packed {
        logic in_valid;
        logic is_end;
        logic fold;
        logic c_blank;
        logic idx_eq_len;
        logic idx_eq_zero;
        logic idx_eq_p1;
        logic rd_blank;
        logic out_free;
    } stat_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic [COL_W-1:0] add_cols(input logic [COL_W-1:0] col,
                                                  input logic [CHAR_W-1:0] c,
                                                  input logic [TW_W-1:0] tw);
        logic [COL_W:0] sum;
        sum = {1'b0, col} + ((c == CH_TAB) ? (COL_W + 1)'(tw) : (COL_W + 1)'(1));
        if (sum > (COL_W + 1)'(COL_SAT))
        begin
            sum = (COL_W + 1)'(COL_SAT);
        end
        return sum[COL_W-1:0];
    endfunction

    // Ring index arithmetic; the sum always stays below twice the depth.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
        logic [LEN_W:0] sum;
        sum = (LEN_W + 1)'(a) + (LEN_W + 1)'(b);
        if (sum >= (LEN_W + 1)'(MAX_WIDTH))
        begin
            sum = sum - (LEN_W + 1)'(MAX_WIDTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/tlf_ifs.sv =====
// Channel interfaces of the text line folder: input, output and configuration.
interface tlf_in_if;
    import tlf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              flush;
    modport source (output valid, output in_char, output flush, input ready);
    modport sink   (input valid, input in_char, input flush, output ready);
endinterface

interface tlf_out_if;
    import tlf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;
    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

interface tlf_cfg_if;
    import tlf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/text_line_folder.sv =====
// Top level of the text line folder: configuration registers and the two blocks.
//
// Folds a byte stream into lines once line_width columns are reached, breaking
// after the last blank of the pending segment. An ordinary byte is accepted and
// then written to the segment store by one store step. A newline or flush emits
// the held segment and then a newline. A fold searches the segment backwards
// for a blank, emits one byte per cycle, and then recounts the remaining bytes.
// The pace is set by the single read port of the segment store, which the
// microcode steps through one entry at a time; a stalled output holds the
// emitting step. Configuration writes are taken in any cycle.
module text_line_folder (
    input  logic      clk,
    input  logic      rst_n,
    tlf_in_if.sink    in_ch,
    tlf_out_if.source out_ch,
    tlf_cfg_if.sink   cfg
);
    import tlf_pkg::*;

    logic [LW_W-1:0] line_width_reg, line_width_next;
    logic [TW_W-1:0] tab_width_reg, tab_width_next;
    ctl_t            ctl;
    stat_t           stat;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        line_width_next = line_width_reg;
        tab_width_next  = tab_width_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LINE_WIDTH: line_width_next = cfg.data[LW_W-1:0];
                REG_TAB_WIDTH:  tab_width_next  = cfg.data[TW_W-1:0];
                default:
                begin
                    line_width_next = line_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LW_RESET;
            tab_width_reg  <= TW_RESET;
        end
        else
        begin
            line_width_reg <= line_width_next;
            tab_width_reg  <= tab_width_next;
        end
    end

    tlf_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    tlf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .line_width (line_width_reg),
        .tab_width  (tab_width_reg),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

endmodule

// ===== src/tlf_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`include "text_line_folder_macros.svh"

module tlf_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  tlf_pkg::stat_t stat,
    output tlf_pkg::ctl_t  ctl
);
    import tlf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F0,
        ST_F1,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_S0,
        ST_S1,
        ST_S2,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_C0,
        ST_H0,
        ST_H1,
        ST_STORE
    } step_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_IDX_EQ_LEN,
        COND_IDX_EQ_ZERO,
        COND_IDX_EQ_P1,
        COND_RD_BLANK
    } cond_t;

    // When the condition holds the step only jumps to tgt; otherwise it
    // performs its actions and moves on to nxt, unless a stalled emit holds it.
    typedef struct packed {
        cond_t cond;
        step_t tgt;
        step_t nxt;
        ctl_t  act;
    } uword_t;

    function automatic uword_t rom(input step_t s);
        uword_t w;
        w.cond = COND_NEVER;
        w.tgt  = ST_IDLE;
        w.nxt  = ST_IDLE;
        w.act  = '0;
        case (s)
            // Newline or flush: whole segment, then a newline.
            ST_F0:
            begin
                w.cond = COND_IDX_EQ_LEN; w.tgt = ST_F1; w.nxt = ST_F0;
                w.act.emit = EMIT_RD; w.act.idx_op = IDX_INC;
            end
            ST_F1:
            begin
                w.act.emit = EMIT_NL; w.act.last = 1'b1; w.act.seg_op = SEG_CLEAR;
            end
            // Fold on an arriving blank: segment, the blank, a newline.
            ST_B0:
            begin
                w.cond = COND_IDX_EQ_LEN; w.tgt = ST_B1; w.nxt = ST_B0;
                w.act.emit = EMIT_RD; w.act.idx_op = IDX_INC;
            end
            ST_B1:
            begin
                w.nxt = ST_B2; w.act.emit = EMIT_CHAR;
            end
            ST_B2:
            begin
                w.act.emit = EMIT_NL; w.act.last = 1'b1; w.act.seg_op = SEG_CLEAR;
            end
            // Backward search for the last blank after the first byte.
            ST_S0:
            begin
                w.nxt = ST_S1; w.act.idx_op = IDX_LEN_M1;
            end
            ST_S1:
            begin
                w.cond = COND_IDX_EQ_ZERO; w.tgt = ST_H0; w.nxt = ST_S2;
            end
            ST_S2:
            begin
                w.cond = COND_RD_BLANK; w.tgt = ST_P0; w.nxt = ST_S1;
                w.act.idx_op = IDX_DEC;
            end
            ST_P0:
            begin
                w.nxt = ST_P1; w.act.p_load = 1'b1; w.act.idx_op = IDX_ZERO;
            end
            ST_P1:
            begin
                w.cond = COND_IDX_EQ_P1; w.tgt = ST_P2; w.nxt = ST_P1;
                w.act.emit = EMIT_RD; w.act.idx_op = IDX_INC;
            end
            ST_P2:
            begin
                w.nxt = ST_C0; w.act.emit = EMIT_NL; w.act.last = 1'b1;
                w.act.seg_op = SEG_ADVANCE; w.act.idx_op = IDX_ZERO;
            end
            // Recount the columns of the remainder.
            ST_C0:
            begin
                w.cond = COND_IDX_EQ_LEN; w.tgt = ST_STORE; w.nxt = ST_C0;
                w.act.col_acc = 1'b1; w.act.idx_op = IDX_INC;
            end
            // No blank found: hard break of the whole segment.
            ST_H0:
            begin
                w.cond = COND_IDX_EQ_LEN; w.tgt = ST_H1; w.nxt = ST_H0;
                w.act.emit = EMIT_RD; w.act.idx_op = IDX_INC;
            end
            ST_H1:
            begin
                w.nxt = ST_STORE; w.act.emit = EMIT_NL; w.act.last = 1'b1;
                w.act.seg_op = SEG_CLEAR;
            end
            ST_STORE:
            begin
                w.act.seg_op = SEG_STORE;
            end
            default:
            begin
                w.nxt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    step_t  upc_reg;
    step_t  upc_next;
    uword_t word;
    logic   cond_hit;
    logic   stall;
    logic   idle;

    always_comb
    begin
        word = rom(upc_reg);
        case (word.cond)
            COND_IDX_EQ_LEN:  cond_hit = stat.idx_eq_len;
            COND_IDX_EQ_ZERO: cond_hit = stat.idx_eq_zero;
            COND_IDX_EQ_P1:   cond_hit = stat.idx_eq_p1;
            COND_RD_BLANK:    cond_hit = stat.rd_blank;
            default:          cond_hit = 1'b0;
        endcase
        stall = (word.act.emit != EMIT_NONE) && !stat.out_free;
        idle  = (upc_reg == ST_IDLE);

        if (idle)
        begin
            if (!stat.in_valid)
            begin
                upc_next = ST_IDLE;
            end
            else if (stat.is_end)
            begin
                upc_next = ST_F0;
            end
            else if (stat.fold)
            begin
                upc_next = stat.c_blank ? ST_B0 : ST_S0;
            end
            else
            begin
                upc_next = ST_STORE;
            end
        end
        else if (cond_hit)
        begin
            upc_next = word.tgt;
        end
        else if (stall)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = word.nxt;
        end

        ctl = '0;
        if (!idle && !cond_hit && !stall)
        begin
            ctl = word.act;
        end
        ctl.idle = idle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    `TLF_ASSERT(a_idle_waits, (upc_reg == ST_IDLE && !stat.in_valid) |=> (upc_reg == ST_IDLE), "sequencer left idle without an item")
    `TLF_ASSERT(a_idle_quiet, ctl.idle |-> (ctl.emit == EMIT_NONE && ctl.seg_op == SEG_NONE), "actions issued while idle")
    `TLF_ASSERT(a_last_on_nl, ctl.last |-> (ctl.emit == EMIT_NL), "final byte of an item is not a newline")

endmodule

// ===== src/tlf_datapath.sv =====
// Datapath: segment ring store, segment registers and output register.
`include "text_line_folder_macros.svh"

module tlf_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlf_pkg::ctl_t              ctl,
    output tlf_pkg::stat_t             stat,
    input  logic [tlf_pkg::LW_W-1:0]   line_width,
    input  logic [tlf_pkg::TW_W-1:0]   tab_width,
    tlf_in_if.sink                     in_ch,
    tlf_out_if.source                  out_ch
);
    import tlf_pkg::*;

    logic [CHAR_W-1:0] seg_mem [MAX_WIDTH];

    logic [ADDR_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [CHAR_W-1:0] rdata_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              fire;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [LEN_W-1:0]  adv;

    assign in_ch.ready     = ctl.idle;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_char_reg;
    assign out_ch.last     = out_last_reg;

    assign accept = ctl.idle && in_ch.valid;
    assign adv    = LEN_W'(p_reg) + LEN_W'(1);

    always_comb
    begin
        stat.in_valid    = in_ch.valid;
        stat.is_end      = in_ch.flush || (in_ch.in_char == CH_NL);
        stat.c_blank     = is_blank(in_ch.in_char);
        stat.fold        = (len_reg != '0) &&
                           ((col_reg >= COL_W'(line_width)) ||
                            (len_reg >= LEN_W'(MAX_WIDTH)));
        stat.idx_eq_len  = (idx_reg == len_reg);
        stat.idx_eq_zero = (idx_reg == '0);
        stat.idx_eq_p1   = (idx_reg == adv);
        stat.rd_blank    = is_blank(rdata_reg);
        stat.out_free    = !out_valid_reg || out_ch.ready;
    end

    always_comb
    begin
        case (ctl.idx_op)
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + LEN_W'(1);
            IDX_DEC:    idx_next = idx_reg - LEN_W'(1);
            IDX_LEN_M1: idx_next = len_reg - LEN_W'(1);
            default:    idx_next = idx_reg;
        endcase
        if (accept)
        begin
            idx_next = '0;
        end

        start_next = start_reg;
        len_next   = len_reg;
        col_next   = col_reg;
        wr_en      = 1'b0;
        wr_addr    = ring_add(start_reg, len_reg);
        case (ctl.seg_op)
            SEG_CLEAR:
            begin
                start_next = '0;
                len_next   = '0;
                col_next   = '0;
            end
            SEG_ADVANCE:
            begin
                start_next = ring_add(start_reg, adv);
                len_next   = len_reg - adv;
                col_next   = '0;
            end
            SEG_STORE:
            begin
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
                col_next = add_cols(col_reg, char_reg, tab_width);
            end
            default:
            begin
                if (ctl.col_acc)
                begin
                    col_next = add_cols(col_reg, rdata_reg, tab_width);
                end
            end
        endcase

        p_next    = ctl.p_load ? idx_reg[ADDR_W-1:0] : p_reg;
        char_next = accept ? in_ch.in_char : char_reg;

        // Read one step ahead so that the read data matches the index register.
        rd_addr = ring_add(start_next, idx_next);

        fire = (ctl.emit != EMIT_NONE);
        case (ctl.emit)
            EMIT_RD:   out_char_next = rdata_reg;
            EMIT_CHAR: out_char_next = char_reg;
            EMIT_NL:   out_char_next = CH_NL;
            default:   out_char_next = out_char_reg;
        endcase
        out_last_next  = fire ? ctl.last : out_last_reg;
        out_valid_next = fire ? 1'b1 : (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            len_reg       <= '0;
            col_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            len_reg       <= len_next;
            col_reg       <= col_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        char_reg     <= char_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[wr_addr] <= char_reg;
        end
        rdata_reg <= seg_mem[rd_addr];
    end

    `TLF_ASSERT_ALWAYS(a_len_bound, len_reg <= LEN_W'(MAX_WIDTH), "segment length beyond store depth")
    `TLF_ASSERT(a_emit_free, (ctl.emit != EMIT_NONE) |-> stat.out_free, "byte emitted into a full output register")
    `TLF_ASSERT(a_store_room, (ctl.seg_op == SEG_STORE) |-> (len_reg < LEN_W'(MAX_WIDTH)), "byte stored into a full segment")

endmodule
